### hdl/dsvm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsvm_pkg: shared types and constants of the drum sample voice mixer
// Sizes of the voice row, the per-voice sample store, the item codes, and the
// command and chain records that pass between the top level and the cells.
// ----------------------------------------------------------------------------
package dsvm_pkg;

  localparam int NUM_VOICES  = 8;
  localparam int VOICE_DEPTH = 16384;
  localparam int SAMPLE_BITS = 16;

  // Fixed field widths of the item and result beats.
  localparam int MODE_W  = 2;
  localparam int VOICE_W = 3;
  localparam int ADDR_W  = 15;
  localparam int IN_W    = 16;
  localparam int MIX_W   = 20;

  // Position indexes one voice area; length may also hold VOICE_DEPTH itself.
  localparam int POS_W = $clog2(VOICE_DEPTH);
  localparam int LEN_W = $clog2(VOICE_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_SET_LEN = 2'd1,
    MODE_TRIGGER = 2'd2,
    MODE_TICK    = 2'd3
  } mode_e;

  // Command broadcast to every cell in the cycle an item is accepted.
  typedef struct packed {
    logic                          load;
    logic                          set_len;
    logic                          trigger;
    logic                          fetch;
    logic [ADDR_W-1:0]             addr;
    logic signed [SAMPLE_BITS-1:0] smp;
  } dsvm_cmd_t;

  // Partial mix handed from one cell to the next.
  typedef struct packed {
    logic                    vld;
    logic                    any;
    logic signed [MIX_W-1:0] acc;
  } dsvm_link_t;

endpackage : dsvm_pkg
`default_nettype wire

### hdl/dsvm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsvm_cell: one drum voice
// Holds the voice's sample area, length, position and play state. On a tick
// it fetches its current sample, then adds it onto the partial mix as the
// mix passes by on the chain.
// ----------------------------------------------------------------------------
module dsvm_cell
  import dsvm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dsvm_cmd_t  cmd_i,
  input  wire logic       sel_i,
  output logic            cfg_o,
  input  wire dsvm_link_t link_i,
  output dsvm_link_t      link_o
);

  logic signed [SAMPLE_BITS-1:0] mem [VOICE_DEPTH];

  logic [LEN_W-1:0]              len_q, len_d;
  logic [POS_W-1:0]              pos_q, pos_d;
  logic                          cfg_q, cfg_d;
  logic                          play_q, play_d;
  logic                          hit_q, hit_d;
  logic signed [SAMPLE_BITS-1:0] rd_q;
  dsvm_link_t                    link_q, link_d;

  logic             wr_en;
  logic [LEN_W-1:0] pos_ext;
  logic [LEN_W-1:0] new_len;

  assign wr_en   = cmd_i.load && sel_i && (32'(cmd_i.addr) < VOICE_DEPTH);
  assign pos_ext = LEN_W'(pos_q);
  assign new_len = (32'(cmd_i.addr) > VOICE_DEPTH) ? LEN_W'(VOICE_DEPTH)
                                                   : LEN_W'(cmd_i.addr);

  always_comb begin
    len_d  = len_q;
    pos_d  = pos_q;
    cfg_d  = cfg_q;
    play_d = play_q;
    hit_d  = hit_q;
    if (cmd_i.set_len && sel_i) begin
      len_d  = new_len;
      cfg_d  = 1'b1;
      pos_d  = '0;
      play_d = 1'b0;
    end else if (cmd_i.trigger && sel_i && cfg_q) begin
      pos_d  = '0;
      play_d = (len_q != '0);
    end else if (cmd_i.fetch) begin
      hit_d = 1'b0;
      if (play_q) begin
        if (pos_ext < len_q) begin
          hit_d = 1'b1;
          // The voice stops right after handing out its last sample.
          if (pos_ext + LEN_W'(1) >= len_q) begin
            pos_d  = '0;
            play_d = 1'b0;
          end else begin
            pos_d = pos_q + POS_W'(1);
          end
        end else begin
          pos_d  = '0;
          play_d = 1'b0;
        end
      end
    end
  end

  always_comb begin
    link_d.vld = link_i.vld;
    link_d.any = link_i.any | hit_q;
    link_d.acc = hit_q ? (link_i.acc + MIX_W'(rd_q)) : link_i.acc;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[POS_W'(cmd_i.addr)] <= cmd_i.smp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      rd_q <= mem[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      pos_q      <= '0;
      cfg_q      <= 1'b0;
      play_q     <= 1'b0;
      hit_q      <= 1'b0;
      link_q.vld <= 1'b0;
      link_q.any <= 1'b0;
      link_q.acc <= '0;
    end else begin
      len_q  <= len_d;
      pos_q  <= pos_d;
      cfg_q  <= cfg_d;
      play_q <= play_d;
      hit_q  <= hit_d;
      link_q <= link_d;
    end
  end

  assign cfg_o  = cfg_q;
  assign link_o = link_q;

endmodule : dsvm_cell
`default_nettype wire

### hdl/drum_sample_voice_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drum_sample_voice_mixer: polyphonic one-shot drum sample player
// Load, length and trigger beats update the voice row; a tick beat sums the
// current sample of every playing voice onto mix_in and returns one result.
// ----------------------------------------------------------------------------
// Items are handled one at a time and every item gives one result beat. A
// load, length or trigger beat is done in the cycle it is accepted and the
// next item can be taken once its result has moved on to the output register.
// A tick beat first fetches one sample from every voice's store in parallel,
// then the partial mix walks down the row of NUM_VOICES voice cells, one cell
// per cycle, and the block stays busy until the tick's result has moved on to
// the output register. A finished result waits in the output register while
// the next item is taken. The sample store needs no clearing after reset:
// playing a sample that was never loaded returns an unspecified value.
module drum_sample_voice_mixer
  import dsvm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [MODE_W-1:0]       mode_i,
  input  wire logic [VOICE_W-1:0]      voice_i,
  input  wire logic [ADDR_W-1:0]       address_i,
  input  wire logic signed [IN_W-1:0]  sample_value_i,
  input  wire logic signed [IN_W-1:0]  mix_in_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic signed [MIX_W-1:0]      mix_out_o,
  output logic                         any_playing_o,
  output logic                         error_o
);

  logic                    busy_q, busy_d;
  logic                    res_valid_q, res_valid_d;
  logic signed [MIX_W-1:0] res_mix_q, res_mix_d;
  logic                    res_any_q, res_any_d;
  logic                    res_err_q, res_err_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [MIX_W-1:0] out_mix_q, out_mix_d;
  logic                    out_any_q, out_any_d;
  logic                    out_err_q, out_err_d;
  dsvm_link_t              launch_q, launch_d;

  logic                  in_acc;
  logic                  out_load;
  logic                  trig_ok;
  dsvm_cmd_t             cmd;
  logic [NUM_VOICES-1:0] sel_vec;
  logic [NUM_VOICES-1:0] cfg_vec;
  logic [NUM_VOICES:0]   vld_vec;
  dsvm_link_t            link [NUM_VOICES+1];

  assign in_acc   = in_valid_i && !busy_q;
  assign out_load = res_valid_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    cmd.load    = in_acc && (mode_i == MODE_LOAD);
    cmd.set_len = in_acc && (mode_i == MODE_SET_LEN);
    cmd.trigger = in_acc && (mode_i == MODE_TRIGGER);
    cmd.fetch   = in_acc && (mode_i == MODE_TICK);
    cmd.addr    = address_i;
    cmd.smp     = SAMPLE_BITS'(sample_value_i);
  end

  assign link[0] = launch_q;

  for (genvar k = 0; k < NUM_VOICES; k++) begin : g_voice
    assign sel_vec[k] = (32'(voice_i) == k);

    dsvm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .sel_i  (sel_vec[k]),
      .cfg_o  (cfg_vec[k]),
      .link_i (link[k]),
      .link_o (link[k+1])
    );
  end

  for (genvar k = 0; k <= NUM_VOICES; k++) begin : g_vld
    assign vld_vec[k] = link[k].vld;
  end

  // A voice number past the row matches no cell, so it reads as unconfigured.
  assign trig_ok = |(sel_vec & cfg_vec);

  always_comb begin
    busy_d      = busy_q;
    res_valid_d = res_valid_q;
    res_mix_d   = res_mix_q;
    res_any_d   = res_any_q;
    res_err_d   = res_err_q;
    launch_d    = launch_q;
    launch_d.vld = 1'b0;

    if (in_acc) begin
      busy_d = 1'b1;
      if (mode_i == MODE_TICK) begin
        launch_d.vld = 1'b1;
        launch_d.any = 1'b0;
        launch_d.acc = MIX_W'(mix_in_i);
      end else begin
        res_valid_d = 1'b1;
        res_mix_d   = '0;
        res_any_d   = 1'b0;
        res_err_d   = (mode_i == MODE_TRIGGER) && !trig_ok;
      end
    end

    if (link[NUM_VOICES].vld) begin
      res_valid_d = 1'b1;
      res_mix_d   = link[NUM_VOICES].acc;
      res_any_d   = link[NUM_VOICES].any;
      res_err_d   = 1'b0;
    end

    if (out_load) begin
      res_valid_d = 1'b0;
      busy_d      = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_mix_d   = out_mix_q;
    out_any_d   = out_any_q;
    out_err_d   = out_err_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_mix_d   = res_mix_q;
      out_any_d   = res_any_q;
      out_err_d   = res_err_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      res_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      launch_q.vld <= 1'b0;
      launch_q.any <= 1'b0;
      launch_q.acc <= '0;
    end else begin
      busy_q      <= busy_d;
      res_valid_q <= res_valid_d;
      out_valid_q <= out_valid_d;
      launch_q    <= launch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_mix_q <= res_mix_d;
    res_any_q <= res_any_d;
    res_err_q <= res_err_d;
    out_mix_q <= out_mix_d;
    out_any_q <= out_any_d;
    out_err_q <= out_err_d;
  end

  assign in_stall_o    = busy_q;
  assign out_valid_o   = out_valid_q;
  assign mix_out_o     = out_mix_q;
  assign any_playing_o = out_any_q;
  assign error_o       = out_err_q;

`ifndef SYNTHESIS
  // Only one partial mix may be on the voice row at any time.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vld_vec))
    else $error("more than one partial mix on the voice row");

  // A mix leaving the row belongs to an item in flight with no result yet.
  a_exit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[NUM_VOICES].vld |-> (busy_q && !res_valid_q))
    else $error("mix left the voice row with no tick in flight");

  // A pending result always belongs to an accepted item.
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> busy_q)
    else $error("pending result while the block is idle");

  // A tick beat puts its mix on the row in the next cycle.
  a_tick_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (mode_i == MODE_TICK)) |=> launch_q.vld)
    else $error("accepted tick did not launch a mix");
`endif

endmodule : drum_sample_voice_mixer
`default_nettype wire

### verif/dsvm_mix_checker.sv
// ----------------------------------------------------------------------------
// dsvm_mix_checker: result predictor and scoreboard for the voice mixer
// Watches the item and result channels of the mixer. Every accepted item beat
// runs through a local model of the voice row and queues the result it must
// give; every accepted result beat is compared field by field with the oldest
// queued result.
// ----------------------------------------------------------------------------
module dsvm_mix_checker
  import dsvm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic [VOICE_W-1:0]      voice_i,
  input  logic [ADDR_W-1:0]       address_i,
  input  logic signed [IN_W-1:0]  sample_value_i,
  input  logic signed [IN_W-1:0]  mix_in_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [MIX_W-1:0] mix_out_i,
  input  logic                    any_playing_i,
  input  logic                    error_i,
  output int                      mismatch_n_o,
  output int                      pending_n_o
);

  typedef struct packed {
    logic signed [MIX_W-1:0] mix;
    logic                    playing;
    logic                    err;
  } mix_result_t;

  // Local copy of the voice row.
  logic signed [SAMPLE_BITS-1:0] voice_samples [NUM_VOICES][VOICE_DEPTH];
  int                            voice_len     [NUM_VOICES];
  int                            voice_pos     [NUM_VOICES];
  bit                            voice_ready   [NUM_VOICES];
  bit                            voice_on      [NUM_VOICES];

  mix_result_t expected_mix_q[$];
  int          mismatch_n = 0;

  assign mismatch_n_o = mismatch_n;

  function automatic mix_result_t predict_mix(mode_e m, int v, int a,
                                               logic signed [IN_W-1:0] smp,
                                               logic signed [IN_W-1:0] mix_in);
    mix_result_t                   res;
    logic signed [SAMPLE_BITS-1:0] s;
    logic signed [MIX_W-1:0]       acc;
    res = '0;
    s   = smp;
    case (m)
      MODE_LOAD: begin
        if (v < NUM_VOICES && a < VOICE_DEPTH) voice_samples[v][a] = s;
      end
      MODE_SET_LEN: begin
        if (v < NUM_VOICES) begin
          voice_len[v]   = (a > VOICE_DEPTH) ? VOICE_DEPTH : a;
          voice_ready[v] = 1'b1;
          voice_pos[v]   = 0;
          voice_on[v]    = 1'b0;
        end
      end
      MODE_TRIGGER: begin
        if (v < NUM_VOICES && voice_ready[v]) begin
          voice_pos[v] = 0;
          voice_on[v]  = (voice_len[v] != 0);
        end else begin
          res.err = 1'b1;
        end
      end
      default: begin
        acc = mix_in;
        for (int k = 0; k < NUM_VOICES; k++) begin
          if (voice_on[k]) begin
            if (voice_pos[k] < voice_len[k] && voice_pos[k] < VOICE_DEPTH) begin
              acc         = acc + voice_samples[k][voice_pos[k]];
              res.playing = 1'b1;
              voice_pos[k]++;
              // A voice drops out right after its last sample.
              if (voice_pos[k] >= voice_len[k]) begin
                voice_pos[k] = 0;
                voice_on[k]  = 1'b0;
              end
            end else begin
              voice_pos[k] = 0;
              voice_on[k]  = 1'b0;
            end
          end
        end
        res.mix = acc;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    mix_result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_VOICES; k++) begin
        voice_len[k]   = 0;
        voice_pos[k]   = 0;
        voice_ready[k] = 1'b0;
        voice_on[k]    = 1'b0;
      end
      expected_mix_q.delete();
    end else begin
      // A result beat always belongs to an earlier item, so retire it first.
      if (out_valid_i && !out_stall_i) begin
        if (expected_mix_q.size() == 0) begin
          mismatch_n++;
          $display("%0t: unexpected result beat: mix_out %0d any_playing %0b error %0b",
                   $time, mix_out_i, any_playing_i, error_i);
        end else begin
          want = expected_mix_q.pop_front();
          if (mix_out_i !== want.mix) begin
            mismatch_n++;
            $display("%0t: mix_out expected %0d, actual %0d", $time, want.mix, mix_out_i);
          end
          if (any_playing_i !== want.playing) begin
            mismatch_n++;
            $display("%0t: any_playing expected %0b, actual %0b",
                     $time, want.playing, any_playing_i);
          end
          if (error_i !== want.err) begin
            mismatch_n++;
            $display("%0t: error expected %0b, actual %0b", $time, want.err, error_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_mix_q.push_back(predict_mix(mode_e'(mode_i), int'(voice_i),
                                             int'(address_i), sample_value_i,
                                             mix_in_i));
      end
    end
    pending_n_o = expected_mix_q.size();
  end

endmodule : dsvm_mix_checker

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the drum sample voice mixer
// Drives a short directed sequence through the special cases of the voice row,
// then random load, length, trigger and tick beats under changing idle and
// stall patterns. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import dsvm_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SHORT_LEN    = 40;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [MODE_W-1:0]       mode_i;
  logic [VOICE_W-1:0]      voice_i;
  logic [ADDR_W-1:0]       address_i;
  logic signed [IN_W-1:0]  sample_value_i;
  logic signed [IN_W-1:0]  mix_in_i;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [MIX_W-1:0] mix_out_o;
  logic                    any_playing_o;
  logic                    error_o;

  int mismatch_n;
  int pending_n;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  // What the stimulus knows of the voice row, so that no voice is ever
  // started over sample entries that were never loaded.
  bit stored_q     [NUM_VOICES][VOICE_DEPTH];
  int filled_n     [NUM_VOICES];
  int len_n        [NUM_VOICES];
  bit configured_q [NUM_VOICES];

  drum_sample_voice_mixer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .voice_i        (voice_i),
    .address_i      (address_i),
    .sample_value_i (sample_value_i),
    .mix_in_i       (mix_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mix_out_o      (mix_out_o),
    .any_playing_o  (any_playing_o),
    .error_o        (error_o)
  );

  dsvm_mix_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .mode_i         (mode_i),
    .voice_i        (voice_i),
    .address_i      (address_i),
    .sample_value_i (sample_value_i),
    .mix_in_i       (mix_in_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mix_out_i      (mix_out_o),
    .any_playing_i  (any_playing_o),
    .error_i        (error_o),
    .mismatch_n_o   (mismatch_n),
    .pending_n_o    (pending_n)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_beat(input mode_e m, input int v, input int a,
                           input int s, input int mx);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    mode_i         = m;
    voice_i        = v[VOICE_W-1:0];
    address_i      = a[ADDR_W-1:0];
    sample_value_i = s[IN_W-1:0];
    mix_in_i       = mx[IN_W-1:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    case (m)
      MODE_LOAD: begin
        if (a < VOICE_DEPTH) begin
          stored_q[v][a] = 1'b1;
          while (filled_n[v] < VOICE_DEPTH && stored_q[v][filled_n[v]]) filled_n[v]++;
        end
      end
      MODE_SET_LEN: begin
        configured_q[v] = 1'b1;
        len_n[v]        = (a > VOICE_DEPTH) ? VOICE_DEPTH : a;
      end
      default: ;
    endcase
  endtask

  initial begin : stimulus
    mode_e m;
    int    v;
    int    a;
    int    s;
    int    mx;
    int    r;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = MODE_TICK;
    voice_i        = '0;
    address_i      = '0;
    sample_value_i = '0;
    mix_in_i       = '0;
    for (int k = 0; k < NUM_VOICES; k++) begin
      filled_n[k]     = 0;
      len_n[k]        = 0;
      configured_q[k] = 1'b0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: empty tick, unconfigured trigger, loads out of range,
    // saturated and zero lengths, retrigger and a length change while playing.
    send_beat(MODE_TICK,    0, 0,     0,      -32768);
    send_beat(MODE_TRIGGER, 3, 0,     0,      0);
    send_beat(MODE_LOAD,    0, 0,     32767,  0);
    send_beat(MODE_LOAD,    0, 1,     -32768, 0);
    send_beat(MODE_LOAD,    0, 2,     1,      0);
    send_beat(MODE_LOAD,    7, 16383, 21845,  -1);
    send_beat(MODE_LOAD,    7, 16384, -1,     0);
    send_beat(MODE_LOAD,    5, 32767, -21846, 0);
    send_beat(MODE_SET_LEN, 0, 3,     0,      0);
    send_beat(MODE_SET_LEN, 1, 0,     0,      0);
    send_beat(MODE_SET_LEN, 2, 32767, 0,      0);
    send_beat(MODE_TRIGGER, 1, 0,     0,      0);
    send_beat(MODE_TICK,    0, 0,     0,      5);
    send_beat(MODE_TRIGGER, 0, 0,     0,      0);
    send_beat(MODE_TICK,    0, 0,     0,      32767);
    send_beat(MODE_TRIGGER, 0, 0,     0,      0);
    send_beat(MODE_TICK,    0, 0,     0,      -32768);
    send_beat(MODE_TICK,    0, 0,     0,      0);
    send_beat(MODE_TICK,    0, 0,     0,      0);
    send_beat(MODE_TICK,    0, 0,     0,      0);
    send_beat(MODE_TRIGGER, 0, 0,     0,      0);
    send_beat(MODE_TICK,    0, 0,     0,      100);
    send_beat(MODE_SET_LEN, 0, 2,     0,      0);
    send_beat(MODE_TICK,    0, 0,     0,      -100);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ((i / 200) % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 76; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 76; end
        default: begin in_idle_pct = 8; out_stall_pct = 8; end
      endcase
      r  = $urandom_range(99);
      v  = $urandom_range(NUM_VOICES - 1);
      a  = 0;
      s  = ($urandom_range(7) == 0) ? (($urandom_range(1) == 1) ? 32767 : -32768)
                                    : int'($urandom_range(65535)) - 32768;
      mx = ($urandom_range(7) == 0) ? (($urandom_range(1) == 1) ? 32767 : -32768)
                                    : int'($urandom_range(65535)) - 32768;
      if (r < 30) begin
        m = MODE_LOAD;
        // Mostly extend the loaded run of a voice so it can be played.
        if ($urandom_range(9) < 8 && filled_n[v] < VOICE_DEPTH) a = filled_n[v];
        else a = $urandom_range(32767);
      end else if (r < 40) begin
        m = MODE_SET_LEN;
        if ($urandom_range(11) == 0) a = $urandom_range(32767);
        else if ($urandom_range(9) == 0) a = filled_n[v] + $urandom_range(3, 1);
        else a = $urandom_range(filled_n[v] < SHORT_LEN ? filled_n[v] : SHORT_LEN);
      end else if (r < 62) begin
        m = MODE_TRIGGER;
        // A voice whose length reaches past its loaded run must not start.
        if (configured_q[v] && len_n[v] > filled_n[v]) m = MODE_TICK;
      end else begin
        m = MODE_TICK;
      end
      send_beat(m, v, a, s, mx);
    end
    in_valid_i = 1'b0;

    while (pending_n != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_n == 0 && pending_n == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : tb

### drum_sample_voice_mixer.f
hdl/dsvm_pkg.sv
hdl/dsvm_cell.sv
hdl/drum_sample_voice_mixer.sv
verif/dsvm_mix_checker.sv
verif/tb.sv
